// ----- hw/rtl/scm_pkg.sv -----
// Shared widths, constants, codes and the item type of the size class mapper.
package scm_pkg;

  // Field widths.
  localparam int SIZE_W  = 24;
  localparam int ALIGN_W = 25;
  localparam int IDX_W   = 8;
  localparam int OBJS_W  = 10;
  localparam int PAGES_W = 14;
  localparam int PS_W    = 5;

  // Page shift limits and reset value.
  localparam logic [PS_W-1:0] PS_MIN   = 5'd12;
  localparam logic [PS_W-1:0] PS_MAX   = 5'd16;
  localparam logic [PS_W-1:0] PS_RESET = 5'd12;

  // Tier boundaries and granule shifts.
  localparam logic [ALIGN_W-1:0] TIER0_END = 25'd128;
  localparam logic [ALIGN_W-1:0] TIER1_END = 25'd1024;
  localparam logic [ALIGN_W-1:0] TIER2_END = 25'd8192;
  localparam logic [ALIGN_W-1:0] TIER3_END = 25'd65536;
  localparam logic [ALIGN_W-1:0] TIER4_END = 25'd262144;
  localparam logic [PS_W-1:0] TIER0_SH = 5'd3;
  localparam logic [PS_W-1:0] TIER1_SH = 5'd4;
  localparam logic [PS_W-1:0] TIER2_SH = 5'd7;
  localparam logic [PS_W-1:0] TIER3_SH = 5'd10;
  localparam logic [PS_W-1:0] TIER4_SH = 5'd13;

  // Buckets in each of the first four tiers, and the first bucket of each tier.
  localparam int TIER_GROUP0 = 16;
  localparam int TIER_GROUP1 = 56;
  localparam int TIER_GROUP2 = 56;
  localparam int TIER_GROUP3 = 56;
  localparam logic [ALIGN_W-1:0] TIER1_BASE = ALIGN_W'(TIER_GROUP0);
  localparam logic [ALIGN_W-1:0] TIER2_BASE = ALIGN_W'(TIER_GROUP0 + TIER_GROUP1);
  localparam logic [ALIGN_W-1:0] TIER3_BASE =
    ALIGN_W'(TIER_GROUP0 + TIER_GROUP1 + TIER_GROUP2);
  localparam logic [ALIGN_W-1:0] TIER4_BASE =
    ALIGN_W'(TIER_GROUP0 + TIER_GROUP1 + TIER_GROUP2 + TIER_GROUP3);

  // Batch sizing.
  localparam int BATCH_BYTES       = 262144;
  localparam int BATCH_BYTES_SHIFT = 18;
  localparam logic [OBJS_W-1:0] BATCH_MIN = 10'd2;
  localparam logic [OBJS_W-1:0] BATCH_MAX = 10'd512;
  // Sizes up to this give the upper clamp; above DIV_LIMIT give the lower clamp.
  localparam logic [SIZE_W-1:0] MAX_CLAMP_SIZE = SIZE_W'(BATCH_BYTES / 512);
  localparam logic [SIZE_W-1:0] DIV_LIMIT      = SIZE_W'(BATCH_BYTES / 2);

  // Restoring divider: quotient below 512, divisor at most DIV_LIMIT.
  localparam int QUO_W     = 9;
  localparam int DIV_STEPS = QUO_W;
  localparam int REM_W     = BATCH_BYTES_SHIFT + 1;
  localparam int DIV_W     = BATCH_BYTES_SHIFT;
  localparam logic [REM_W-1:0] DIV_INIT = REM_W'(BATCH_BYTES);

  // Largest batch total is twice the largest size, under 2^25.
  localparam int TOTAL_W = 26;

  // Queue between front and back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // Batch count selection codes.
  localparam logic [1:0] BATCH_ZERO = 2'd0;
  localparam logic [1:0] BATCH_LOW  = 2'd1;
  localparam logic [1:0] BATCH_HIGH = 2'd2;
  localparam logic [1:0] BATCH_DIV  = 2'd3;

  // One classified request as it travels from front to back.
  typedef struct packed {
    logic [ALIGN_W-1:0] aligned_size;
    logic [IDX_W-1:0]   bucket_index;
    logic               bucket_valid;
    logic [1:0]         batch_sel;
    logic [SIZE_W-1:0]  size;
  } scm_item_t;

endpackage

// ----- hw/rtl/scm_front.sv -----
// Front end: rounds the size to its tier and works out the bucket and batch class.
module scm_front import scm_pkg::*; (
  input  logic [SIZE_W-1:0] request_size,
  input  logic [PS_W-1:0]   page_shift,
  output scm_item_t         item
);

  // Round v up to a multiple of 2^sh.
  function automatic logic [ALIGN_W-1:0] round_up(input logic [ALIGN_W-1:0] v,
                                                  input logic [PS_W-1:0] sh);
    logic [ALIGN_W-1:0] mask;
    mask = (ALIGN_W'(1) << sh) - ALIGN_W'(1);
    return (v + mask) & ~mask;
  endfunction

  // Slot of v inside a tier of granule 2^sh, v at least one.
  function automatic logic [ALIGN_W-1:0] tier_slot(input logic [ALIGN_W-1:0] v,
                                                   input logic [PS_W-1:0] sh);
    logic [ALIGN_W-1:0] mask;
    mask = (ALIGN_W'(1) << sh) - ALIGN_W'(1);
    return ((v + mask) >> sh) - ALIGN_W'(1);
  endfunction

  logic [ALIGN_W-1:0] sz;
  logic [ALIGN_W-1:0] idx_wide;

  assign sz = {1'b0, request_size};

  // Tier selection, alignment, bucket index and batch class.
  always_comb begin
    idx_wide          = '0;
    item.bucket_valid = 1'b1;
    if (sz == '0) begin
      item.aligned_size = '0;
      item.bucket_valid = 1'b0;
    end else if (sz <= TIER0_END) begin
      item.aligned_size = round_up(sz, TIER0_SH);
      idx_wide          = tier_slot(sz, TIER0_SH);
    end else if (sz <= TIER1_END) begin
      item.aligned_size = round_up(sz, TIER1_SH);
      idx_wide          = tier_slot(sz - TIER0_END, TIER1_SH) + TIER1_BASE;
    end else if (sz <= TIER2_END) begin
      item.aligned_size = round_up(sz, TIER2_SH);
      idx_wide          = tier_slot(sz - TIER1_END, TIER2_SH) + TIER2_BASE;
    end else if (sz <= TIER3_END) begin
      item.aligned_size = round_up(sz, TIER3_SH);
      idx_wide          = tier_slot(sz - TIER2_END, TIER3_SH) + TIER3_BASE;
    end else if (sz <= TIER4_END) begin
      item.aligned_size = round_up(sz, TIER4_SH);
      idx_wide          = tier_slot(sz - TIER3_END, TIER4_SH) + TIER4_BASE;
    end else begin
      item.aligned_size = round_up(sz, page_shift);
      item.bucket_valid = 1'b0;
    end
    item.bucket_index = idx_wide[IDX_W-1:0];

    // Batch class: only the middle range needs the divider.
    if (request_size == '0) begin
      item.batch_sel = BATCH_ZERO;
    end else if (request_size <= MAX_CLAMP_SIZE) begin
      item.batch_sel = BATCH_HIGH;
    end else if (request_size > DIV_LIMIT) begin
      item.batch_sel = BATCH_LOW;
    end else begin
      item.batch_sel = BATCH_DIV;
    end

    item.size = request_size;
  end

endmodule

// ----- hw/rtl/scm_queue.sv -----
// Four-entry queue that decouples the front end from the back end.
module scm_queue import scm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  scm_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output scm_item_t pop_item
);

  scm_item_t            entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic                 push;
  logic                 pop;

  assign push_ready = (count != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = entries[rd_ptr];

  // Pointer and fill count update.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + Q_PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + Q_PTR_W'(1);
      if (push && !pop) count <= count + Q_CNT_W'(1);
      else if (pop && !push) count <= count - Q_CNT_W'(1);
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

  // The fill count never passes the depth and tracks pushes and pops.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue fill count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + Q_CNT_W'(1))
    else $error("queue fill count missed a push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - Q_CNT_W'(1))
    else $error("queue fill count missed a pop");

endmodule

// ----- hw/rtl/scm_back.sv -----
// Back end: pipelined batch divider, batch total multiplier and page count.
module scm_back import scm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [PS_W-1:0]     page_shift,
  input  logic                in_valid,
  output logic                in_ready,
  input  scm_item_t           in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ALIGN_W-1:0]  aligned_size,
  output logic [IDX_W-1:0]    bucket_index,
  output logic                bucket_valid,
  output logic [OBJS_W-1:0]   batch_objects,
  output logic [PAGES_W-1:0]  pages_needed
);

  localparam int STAGES  = DIV_STEPS + 2;
  localparam int MUL_STG = DIV_STEPS;
  localparam int OUT_STG = DIV_STEPS + 1;

  logic [STAGES-1:0] vld;
  logic [STAGES:0]   rdy;

  scm_item_t          div_item [DIV_STEPS];
  logic [REM_W-1:0]   div_rem  [DIV_STEPS];
  logic [QUO_W-1:0]   div_quo  [DIV_STEPS];

  scm_item_t          mul_item;
  logic [OBJS_W-1:0]  mul_objs;
  logic [TOTAL_W-1:0] mul_total;
  logic [OBJS_W-1:0]  objs_sel;
  logic [OBJS_W+SIZE_W-1:0] product;

  logic [TOTAL_W:0]   round_sum;
  logic [TOTAL_W:0]   pages_full;

  // Ready chain: a stage takes a word when empty or when its word moves on.
  assign rdy[STAGES] = out_ready;
  genvar g;
  generate
    for (g = 0; g < STAGES; g++) begin : g_rdy
      assign rdy[g] = !vld[g] || rdy[g+1];
    end
  endgenerate

  assign in_ready  = rdy[0];
  assign out_valid = vld[OUT_STG];

  // Valid bits of all stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (rdy[k]) vld[k] <= (k == 0) ? in_valid : vld[(k == 0) ? 0 : k-1];
      end
    end
  end

  // Restoring division of BATCH_BYTES by the size, one quotient bit per stage.
  generate
    for (g = 0; g < DIV_STEPS; g++) begin : g_div
      scm_item_t                 item_src;
      logic [REM_W-1:0]          rem_src;
      logic [QUO_W-1:0]          quo_src;
      logic [DIV_W+QUO_W-1:0]    dshift;
      logic [REM_W-1:0]          rem_next;
      logic [QUO_W-1:0]          quo_next;

      if (g == 0) begin : g_first
        assign item_src = in_item;
        assign rem_src  = DIV_INIT;
        assign quo_src  = '0;
      end else begin : g_rest
        assign item_src = div_item[g-1];
        assign rem_src  = div_rem[g-1];
        assign quo_src  = div_quo[g-1];
      end

      // Trial subtract of the divisor at this quotient bit.
      always_comb begin
        dshift   = {{QUO_W{1'b0}}, item_src.size[DIV_W-1:0]} << (DIV_STEPS - 1 - g);
        rem_next = rem_src;
        quo_next = quo_src;
        if ((DIV_W+QUO_W)'(rem_src) >= dshift) begin
          rem_next = rem_src - dshift[REM_W-1:0];
          quo_next = quo_src | (QUO_W'(1) << (DIV_STEPS - 1 - g));
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[g]) begin
          div_item[g] <= item_src;
          div_rem[g]  <= rem_next;
          div_quo[g]  <= quo_next;
        end
      end
    end
  endgenerate

  // Batch count from the class, then the batch total.
  always_comb begin
    case (div_item[DIV_STEPS-1].batch_sel)
      BATCH_ZERO: objs_sel = '0;
      BATCH_LOW:  objs_sel = BATCH_MIN;
      BATCH_HIGH: objs_sel = BATCH_MAX;
      default:    objs_sel = {1'b0, div_quo[DIV_STEPS-1]};
    endcase
  end

  assign product = objs_sel * div_item[DIV_STEPS-1].size;

  always_ff @(posedge clk) begin
    if (rdy[MUL_STG]) begin
      mul_item  <= div_item[DIV_STEPS-1];
      mul_objs  <= objs_sel;
      mul_total <= product[TOTAL_W-1:0];
    end
  end

  // Page count, rounded up, into the output register.
  assign round_sum  = {1'b0, mul_total} + ((TOTAL_W+1)'(1) << page_shift)
                      - (TOTAL_W+1)'(1);
  assign pages_full = round_sum >> page_shift;

  always_ff @(posedge clk) begin
    if (rdy[OUT_STG]) begin
      aligned_size  <= mul_item.aligned_size;
      bucket_index  <= mul_item.bucket_index;
      bucket_valid  <= mul_item.bucket_valid;
      batch_objects <= mul_objs;
      pages_needed  <= pages_full[PAGES_W-1:0];
    end
  end

endmodule

// ----- hw/rtl/size_class_mapper_core.sv -----
// Throughput: one word per cycle while out_ready holds; the queue decouples
// classification from the eleven-stage back end (nine divider stages,
// multiplier, page count).
// Reset clears the queue and all stage valid bits and sets page_shift to 12.
// Top level of the size class mapper: page shift register, front, queue, back.
module size_class_mapper_core import scm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [PS_W-1:0]    cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SIZE_W-1:0]  request_size,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ALIGN_W-1:0] aligned_size,
  output logic [IDX_W-1:0]   bucket_index,
  output logic               bucket_valid,
  output logic [OBJS_W-1:0]  batch_objects,
  output logic [PAGES_W-1:0] pages_needed
);

  logic [PS_W-1:0] page_shift;
  logic [PS_W-1:0] ps_eff;
  scm_item_t       front_item;
  scm_item_t       q_item;
  logic            q_valid;
  logic            q_ready;

  // Page shift register.
  always_ff @(posedge clk) begin
    if (rst) begin
      page_shift <= PS_RESET;
    end else if (cfg_wr_en) begin
      page_shift <= cfg_wr_data;
    end
  end

  // Clamp the page shift to its legal range.
  always_comb begin
    if (page_shift < PS_MIN) begin
      ps_eff = PS_MIN;
    end else if (page_shift > PS_MAX) begin
      ps_eff = PS_MAX;
    end else begin
      ps_eff = page_shift;
    end
  end

  scm_front u_front (
    .request_size (request_size),
    .page_shift   (ps_eff),
    .item         (front_item)
  );

  scm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_item  (front_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  scm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .page_shift    (ps_eff),
    .in_valid      (q_valid),
    .in_ready      (q_ready),
    .in_item       (q_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .aligned_size  (aligned_size),
    .bucket_index  (bucket_index),
    .bucket_valid  (bucket_valid),
    .batch_objects (batch_objects),
    .pages_needed  (pages_needed)
  );

endmodule
